### sv/ubds_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ubds_pkg: shared types and constants
// Widths, reset value and inter-module structs of the baud divisor selector.
// ---------------------------------------------------------------------------
package ubds_pkg;

    localparam int FREQ_W  = 32;              // clock frequency, dividend
    localparam int BAUD_W  = 24;              // baud rate
    localparam int DVS_W   = BAUD_W + 3;      // x8 step, divisor of the cell chain
    localparam int STEP_W  = BAUD_W + 4;      // x16 step, widest step
    localparam int DIV_W   = 16;              // divisor register value
    localparam int ERR_W   = 32;              // frequency error
    localparam int N_CELLS = FREQ_W;          // one quotient bit per cell

    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(32'd16000000);
    localparam logic [DIV_W-1:0]  DIV_MAX    = {DIV_W{1'b1}};

    // word travelling down the divider chain
    typedef struct packed {
        logic              valid;
        logic [BAUD_W-1:0] baud;
        logic [DVS_W-1:0]  rem;   // partial remainder
        logic [FREQ_W-1:0] word;  // dividend bits out at the top, quotient bits in
    } div_word_t;

    // rounding result for one oversampling factor
    typedef struct packed {
        logic [DIV_W-1:0] div;
        logic [ERR_W-1:0] err;
    } pick_res_t;

endpackage : ubds_pkg
`default_nettype wire

### sv/ubds_div_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ubds_div_cell: one restoring division cell
// Takes one dividend bit, subtracts the x8 step if it fits, emits a quotient bit.
// ---------------------------------------------------------------------------
module ubds_div_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                run,
    input  wire ubds_pkg::div_word_t word_in,
    output      ubds_pkg::div_word_t word_out
);
    import ubds_pkg::*;

    div_word_t            cell_reg;
    div_word_t            cell_next;
    logic [DVS_W-1:0]     dvs;
    logic [DVS_W:0]       partial;
    logic                 fits;

    always_comb
    begin
        dvs       = {word_in.baud, 3'b000};
        partial   = {word_in.rem, word_in.word[FREQ_W-1]};
        fits      = (partial >= {1'b0, dvs});
        cell_next = word_in;
        // drop the subtracted step; remainder stays below the step
        cell_next.rem  = fits ? DVS_W'(partial - {1'b0, dvs}) : partial[DVS_W-1:0];
        cell_next.word = {word_in.word[FREQ_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (run)
        begin
            cell_reg <= cell_next;
        end
    end

    assign word_out = cell_reg;

endmodule : ubds_div_cell
`default_nettype wire

### sv/ubds_pick.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ubds_pick: nearest-multiple rounding for one oversampling factor
// From quotient and remainder of F / step, form the divisor and its error.
// ---------------------------------------------------------------------------
module ubds_pick (
    input  wire logic [ubds_pkg::FREQ_W-1:0] freq,
    input  wire logic [ubds_pkg::STEP_W-1:0] step,
    input  wire logic [ubds_pkg::FREQ_W-1:0] quo,
    input  wire logic [ubds_pkg::STEP_W-1:0] rem,
    output      ubds_pkg::pick_res_t         res
);
    import ubds_pkg::*;

    logic [STEP_W-1:0] dist_up;
    logic              round_up;
    logic [FREQ_W-1:0] mult;
    logic              mult_zero;
    logic              mult_sat;

    always_comb
    begin
        dist_up   = step - rem;
        round_up  = (dist_up < (step >> 1));
        mult      = quo + FREQ_W'(round_up);
        mult_zero = (mult == '0);
        mult_sat  = (mult > FREQ_W'(33'h1_0000));

        if (mult_zero)
        begin
            // clamp to divisor 0: freq is below the step here
            res.div = '0;
            res.err = ERR_W'(step - freq[STEP_W-1:0]);
        end
        else if (mult_sat)
        begin
            // saturate; 65536 steps never exceed freq in this case
            res.div = DIV_MAX;
            res.err = ERR_W'(freq - {step[FREQ_W-DIV_W-1:0], {DIV_W{1'b0}}});
        end
        else
        begin
            res.div = DIV_W'(mult - FREQ_W'(1));
            res.err = round_up ? ERR_W'(dist_up) : ERR_W'(rem);
        end
    end

endmodule : ubds_pick
`default_nettype wire

### sv/uart_baud_divisor_select.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uart_baud_divisor_select: UART baud divisor selection
// Picks the divisor and speed mode with the smallest clock error for a baud.
// ---------------------------------------------------------------------------
// For each baud_rate word the block returns the UART divisor register value,
// the speed flag (1 = x8 double speed, 0 = x16 normal) and the absolute error
// in hertz against clock_frequency. The divisor is the nearest multiple of
// baud*factor minus one; an exact half step rounds down, a negative divisor
// clamps to 0, a divisor above 65535 saturates, and normal speed wins a tie.
// A zero baud rate returns divisor 65535, normal speed and the clock itself
// as error. The block takes one word per cycle while in_stall is low; each
// accepted word passes 32 division cells, each yielding one quotient bit of
// clock_frequency / (8*baud), then a split stage, a rounding stage and the
// output register. The x16 quotient and remainder are derived from the
// x8 ones, so one divider chain serves both factors. A one-word skid register
// behind the output register absorbs a stall; in_stall rises only while it is
// full. Write clock_frequency (cfg_we/cfg_data) only while the block is empty.
// ---------------------------------------------------------------------------
module uart_baud_divisor_select (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [ubds_pkg::FREQ_W-1:0] cfg_data,
    // request channel
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire logic [ubds_pkg::BAUD_W-1:0] baud_rate,
    // result channel
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      logic [ubds_pkg::DIV_W-1:0]  divisor_value,
    output      logic                        double_speed,
    output      logic [ubds_pkg::ERR_W-1:0]  rate_error
);
    import ubds_pkg::*;

    typedef struct packed {
        logic [DIV_W-1:0] div;
        logic             dbl;
        logic [ERR_W-1:0] err;
    } result_t;

    logic [FREQ_W-1:0] freq_reg;

    // divider chain
    div_word_t         chain [N_CELLS+1];
    logic              run;

    // split stage
    logic              s1_valid_reg;
    logic              s1_zero_reg;
    logic [STEP_W-1:0] s1_step_n_reg;
    logic [STEP_W-1:0] s1_step_d_reg;
    logic [FREQ_W-1:0] s1_quo_n_reg;
    logic [STEP_W-1:0] s1_rem_n_reg;
    logic [FREQ_W-1:0] s1_quo_d_reg;
    logic [STEP_W-1:0] s1_rem_d_reg;

    // rounding stage
    pick_res_t         pick_n;
    pick_res_t         pick_d;
    logic              s2_valid_reg;
    logic              s2_zero_reg;
    pick_res_t         s2_n_reg;
    pick_res_t         s2_d_reg;

    // output and skid
    result_t           sel;
    result_t           out_reg;
    result_t           skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              out_take;
    logic              out_push;

    // -----------------------------------------------------------------------
    // clock frequency register, unchecked: write only while block is empty
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= FREQ_RESET;
        end
        else if (cfg_we)
        begin
            freq_reg <= cfg_data;
        end
    end

    // Advance the whole pipe unless the skid register holds a word.
    assign run      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // -----------------------------------------------------------------------
    // Divider chain: clock_frequency / (8*baud), one quotient bit per cell.
    // The dividend enters whole and shifts out as quotient bits shift in.
    // -----------------------------------------------------------------------
    always_comb
    begin
        chain[0].valid = in_valid && !in_stall;
        chain[0].baud  = baud_rate;
        chain[0].rem   = '0;
        chain[0].word  = freq_reg;
    end

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        ubds_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .run      (run),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    // -----------------------------------------------------------------------
    // Split stage: derive the x16 quotient and remainder from the x8 ones.
    // q16 = q8 / 2, r16 = r8 + (odd q8 ? 8*baud : 0).
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (run)
        begin
            s1_valid_reg <= chain[N_CELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            s1_zero_reg   <= (chain[N_CELLS].baud == '0);
            s1_step_n_reg <= {chain[N_CELLS].baud, 4'b0000};
            s1_step_d_reg <= STEP_W'({chain[N_CELLS].baud, 3'b000});
            s1_quo_n_reg  <= chain[N_CELLS].word >> 1;
            s1_rem_n_reg  <= STEP_W'(chain[N_CELLS].rem)
                           + (chain[N_CELLS].word[0] ?
                              STEP_W'({chain[N_CELLS].baud, 3'b000}) : '0);
            s1_quo_d_reg  <= chain[N_CELLS].word;
            s1_rem_d_reg  <= STEP_W'(chain[N_CELLS].rem);
        end
    end

    // -----------------------------------------------------------------------
    // Rounding stage: nearest multiple, clamp and saturate for each factor.
    // -----------------------------------------------------------------------
    ubds_pick u_pick_n (
        .freq (freq_reg),
        .step (s1_step_n_reg),
        .quo  (s1_quo_n_reg),
        .rem  (s1_rem_n_reg),
        .res  (pick_n)
    );

    ubds_pick u_pick_d (
        .freq (freq_reg),
        .step (s1_step_d_reg),
        .quo  (s1_quo_d_reg),
        .rem  (s1_rem_d_reg),
        .res  (pick_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (run)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            s2_zero_reg <= s1_zero_reg;
            s2_n_reg    <= pick_n;
            s2_d_reg    <= pick_d;
        end
    end

    // -----------------------------------------------------------------------
    // Select: smaller error wins, normal speed on a tie; zero baud is fixed.
    // -----------------------------------------------------------------------
    always_comb
    begin
        if (s2_zero_reg)
        begin
            sel.div = DIV_MAX;
            sel.dbl = 1'b0;
            sel.err = ERR_W'(freq_reg);
        end
        else if (s2_n_reg.err <= s2_d_reg.err)
        begin
            sel.div = s2_n_reg.div;
            sel.dbl = 1'b0;
            sel.err = s2_n_reg.err;
        end
        else
        begin
            sel.div = s2_d_reg.div;
            sel.dbl = 1'b1;
            sel.err = s2_d_reg.err;
        end
    end

    // -----------------------------------------------------------------------
    // Output register with one skid word. A word arriving while the output
    // is held lands in the skid register, which then stops the pipe.
    // -----------------------------------------------------------------------
    assign out_take = out_valid_reg && !out_stall;
    assign out_push = run && s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_push)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (out_push)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= sel;
            end
            else
            begin
                out_reg <= sel;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign divisor_value = out_reg.div;
    assign double_speed  = out_reg.dbl;
    assign rate_error    = out_reg.err;

endmodule : uart_baud_divisor_select
`default_nettype wire
